FILE: rtl/core/u2h_pkg.sv
// Package with the shared types, constants and the hex_ascii helper function of the UTF-8 to UCS-2 decoder.
package u2h_pkg;

  localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;
  localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

  // Number of continuation bytes still expected in the current sequence.
  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_ONE   = 2'd1;
  localparam logic [1:0] PEND_TWO   = 2'd2;
  localparam logic [1:0] PEND_THREE = 2'd3;

  localparam logic [1:0] DIGIT_LAST = 2'd3;

  // One decoded item handed from the decoder to the output sequencer.
  typedef struct packed {
    logic        has_unit;
    logic [15:0] unit;
    logic        hex;
    logic        last;
    logic [15:0] count;
  } u2h_job_t;

  function automatic logic [15:0] hex_ascii(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h41 + {4'd0, nib} - 8'd10;
    end
    return {8'd0, ch};
  endfunction

endpackage

FILE: rtl/core/u2h_ifs.sv
// Handshake interfaces for the byte input channel and the result output channel.
interface u2h_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface u2h_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_value;
  logic        out_end;
  logic [15:0] unit_count;

  modport source (output valid, output out_value, output out_end, output unit_count,
                  input ready);
  modport sink (input valid, input out_value, input out_end, input unit_count,
                output ready);
endinterface

FILE: rtl/core/u2h_decoder.sv
// UTF-8 sequence decoder: per-string state and the decode of one byte per accepted item.
module u2h_decoder (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          hex_mode,
  output u2h_pkg::u2h_job_t job
);

  logic        halted;
  logic [1:0]  pend;
  logic [15:0] accum;
  logic        beyond;
  logic [15:0] units;

  logic        halted_next;
  logic [1:0]  pend_next;
  logic [15:0] accum_next;
  logic        beyond_next;
  logic [15:0] units_next;
  logic        emit;
  logic [15:0] unit;

  always_comb begin
    halted_next = halted;
    pend_next   = pend;
    accum_next  = accum;
    beyond_next = beyond;
    emit        = 1'b0;
    unit        = {8'd0, in_byte};
    if (!halted) begin
      if (pend != u2h_pkg::PEND_NONE) begin
        if (in_byte[7:6] != 2'b10) begin
          halted_next = 1'b1;
          pend_next   = u2h_pkg::PEND_NONE;
        end else begin
          accum_next = {accum[9:0], in_byte[5:0]};
          pend_next  = pend - 2'd1;
          if (pend == u2h_pkg::PEND_ONE) begin
            emit = 1'b1;
            unit = beyond ? u2h_pkg::REPLACEMENT_UNIT : accum_next;
          end
        end
      end else if (in_byte == 8'h00) begin
        halted_next = 1'b1;
      end else if (!in_byte[7]) begin
        emit = 1'b1;
      end else if (in_byte[7:5] == 3'b110) begin
        accum_next  = {11'd0, in_byte[4:0]};
        beyond_next = 1'b0;
        pend_next   = u2h_pkg::PEND_ONE;
      end else if (in_byte[7:4] == 4'b1110) begin
        accum_next  = {12'd0, in_byte[3:0]};
        beyond_next = 1'b0;
        pend_next   = u2h_pkg::PEND_TWO;
      end else if (in_byte[7:3] == 5'b11110) begin
        accum_next  = {13'd0, in_byte[2:0]};
        beyond_next = 1'b1;
        pend_next   = u2h_pkg::PEND_THREE;
      end
    end
    units_next = (emit && units != u2h_pkg::COUNT_MAX) ? units + 16'd1 : units;
  end

  assign job.has_unit = emit;
  assign job.unit     = unit;
  assign job.hex      = hex_mode;
  assign job.last     = in_last;
  assign job.count    = units_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      halted <= 1'b0;
      pend   <= u2h_pkg::PEND_NONE;
      accum  <= 16'd0;
      beyond <= 1'b0;
      units  <= 16'd0;
    end else if (accept) begin
      if (in_last) begin
        // The string ends here, so the next byte starts a fresh string.
        halted <= 1'b0;
        pend   <= u2h_pkg::PEND_NONE;
        accum  <= 16'd0;
        beyond <= 1'b0;
        units  <= 16'd0;
      end else begin
        halted <= halted_next;
        pend   <= pend_next;
        accum  <= accum_next;
        beyond <= beyond_next;
        units  <= units_next;
      end
    end
  end

endmodule

FILE: rtl/core/u2h_emitter.sv
// Result register and sequencer that sends a decoded item as one to five results.
module u2h_emitter (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  u2h_pkg::u2h_job_t   job,
  output logic                free,
  u2h_unit_if.source          res
);

  logic              busy;
  u2h_pkg::u2h_job_t held;
  logic              unit_left;
  logic [1:0]        digit;
  logic [3:0]        nib;
  logic              final_res;
  logic              taken;

  always_comb begin
    case (digit)
      2'd0:    nib = held.unit[15:12];
      2'd1:    nib = held.unit[11:8];
      2'd2:    nib = held.unit[7:4];
      default: nib = held.unit[3:0];
    endcase
  end

  assign final_res = !unit_left ||
                     (!held.last && (!held.hex || digit == u2h_pkg::DIGIT_LAST));
  assign taken     = res.valid && res.ready;
  assign free      = !busy || (taken && final_res);

  assign res.valid      = busy;
  assign res.out_end    = !unit_left;
  assign res.unit_count = unit_left ? 16'd0 : held.count;
  assign res.out_value  = !unit_left ? 16'd0 :
                          held.hex ? u2h_pkg::hex_ascii(nib) : held.unit;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      unit_left <= 1'b0;
      digit     <= 2'd0;
    end else if (free) begin
      busy      <= load;
      unit_left <= job.has_unit;
      digit     <= 2'd0;
    end else if (taken) begin
      if (held.hex && digit != u2h_pkg::DIGIT_LAST) begin
        digit <= digit + 2'd1;
      end else begin
        unit_left <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= job;
    end
  end

endmodule

FILE: rtl/core/utf8_to_ucs2_hex_stream_unit.sv
// Top level of the UTF-8 to UCS-2 decoder with optional hex text output.
// The first result of an item is valid in the cycle after the item is accepted.
// Results leave at one per cycle while the output port is ready; an item gives up to
// five results (in hex mode on a string's last byte).
// A new item is taken in the same cycle the last result of the previous one leaves.
// Reset (rst, synchronous) clears the decode state, the result register and hex_mode.
module utf8_to_ucs2_hex_stream_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  u2h_byte_if.sink   bytes_in,
  u2h_unit_if.source units_out
);

  // Output format register: raw code units when low, four ASCII hex digits when high.
  logic hex_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      hex_mode <= 1'b0;
    end else if (cfg_we) begin
      hex_mode <= cfg_wdata;
    end
  end

  u2h_pkg::u2h_job_t job;
  logic              free;
  logic              accept;

  // The input is ready whenever the result register is empty or is handing over its
  // final result in this cycle, so a stalled output never blocks more than one item.
  assign bytes_in.ready = free;
  assign accept         = bytes_in.valid && free;

  // The decoder updates the per-string state on every accepted byte and reports whether
  // that byte completed a code unit, together with the running unit count.
  u2h_decoder u_decoder (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (bytes_in.in_byte),
    .in_last  (bytes_in.in_last),
    .hex_mode (hex_mode),
    .job      (job)
  );

  // Only items that give at least one result (a finished unit or the string's end)
  // enter the result register; skipped and partial bytes leave no trace there.
  u2h_emitter u_emitter (
    .clk  (clk),
    .rst  (rst),
    .load (accept && (job.has_unit || job.last)),
    .job  (job),
    .free (free),
    .res  (units_out)
  );

endmodule
